// ===== hw/rtl/fqmm_pkg.sv =====
// shared types and constants for the fifo queue with min/max scan
`default_nettype none

package fqmm_pkg;

  localparam int unsigned DATA_W = 32;

  // the four item actions
  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_DISP   = 2'd2,
    ACT_MINMAX = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_DEQ,
    S_DISP,
    S_MM,
    S_MM_OUT
  } state_e;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== hw/rtl/fqmm_in_if.sv =====
// input channel: one action beat with its value
`default_nettype none

interface fqmm_in_if;
  import fqmm_pkg::*;

  logic    valid;
  logic    ready;
  action_e action;
  data_t   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fqmm_out_if.sv =====
// output channel: one result beat
`default_nettype none

interface fqmm_out_if;
  import fqmm_pkg::*;

  logic    valid;
  logic    ready;
  status_e status;
  data_t   item_value;
  data_t   min_value;
  data_t   max_value;
  logic    last;

  modport source (output valid, output status, output item_value, output min_value,
                  output max_value, output last, input ready);
  modport sink   (input valid, input status, input item_value, input min_value,
                  input max_value, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fifo_queue_min_max_scan.sv =====
// top level: bounded fifo of signed values with display and min/max scan
// enqueue, dequeue and every empty/full report give one result beat, which S_RESP or
//   S_DEQ loads into the output register once that register is free
// display of n values: the head is read on accept, then one beat a cycle while
//   the output register is free; min/max: one value a cycle, then one result beat
// the input waits while an item is in the sequencer; the output register holds a beat
// reset clears head, tail, occupancy and the sequencer; the ram is not cleared
`default_nettype none

module fifo_queue_min_max_scan #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fqmm_in_if.sink    in_i,
  fqmm_out_if.source out_o
);
  import fqmm_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);

  // ring index advance, wraps at DEPTH which need not be a power of two
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  // sequencer and queue pointers
  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [OW-1:0] occ_q, occ_d;

  // scan walker: next slot to read and values still to handle
  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [OW-1:0] scan_cnt_q, scan_cnt_d;

  // running extremes of the shared compare unit
  data_t mn_q, mn_d;
  data_t mx_q, mx_d;

  // status of a single pending result
  status_e res_status_q, res_status_d;

  // output register
  logic    out_valid_q, out_valid_d;
  status_e out_status_q;
  data_t   out_item_q, out_min_q, out_max_q;
  logic    out_last_q;

  // load request into the output register
  logic    load_out;
  status_e ld_status;
  data_t   ld_item, ld_min, ld_max;
  logic    ld_last;

  // ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  data_t         rd_value;

  logic in_fire, out_free, full, empty;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign full     = (occ_q == OW'(DEPTH));
  assign empty    = (occ_q == '0);
  assign rd_value = $signed(ram_rdata);

  // one item at a time: the input opens only when the sequencer is idle
  assign in_i.ready = (state_q == S_IDLE);

  fqmm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    scan_idx_q   <= scan_idx_d;
    mn_q         <= mn_d;
    mx_q         <= mx_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      out_status_q <= ld_status;
      out_item_q   <= ld_item;
      out_min_q    <= ld_min;
      out_max_q    <= ld_max;
      out_last_q   <= ld_last;
    end
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    scan_idx_d   = scan_idx_q;
    scan_cnt_d   = scan_cnt_q;
    mn_d         = mn_q;
    mx_d         = mx_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    load_out     = 1'b0;
    ld_status    = ST_OK;
    ld_item      = '0;
    ld_min       = '0;
    ld_max       = '0;
    ld_last      = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.action == ACT_ENQ) begin
            // store at the tail, or drop and report full
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              ram_we       = 1'b1;
              tail_d       = next_slot(tail_q);
              occ_d        = occ_q + OW'(1);
              res_status_d = ST_OK;
            end
            state_d = S_RESP;
          end else if (empty) begin
            res_status_d = ST_EMPTY;
            state_d      = S_RESP;
          end else begin
            // every other action starts by reading the oldest entry
            ram_re     = 1'b1;
            ram_raddr  = head_q;
            scan_idx_d = next_slot(head_q);
            scan_cnt_d = occ_q;
            mn_d       = DATA_MAX;
            mx_d       = DATA_MIN;
            priority if (in_i.action == ACT_DEQ) begin
              head_d  = next_slot(head_q);
              occ_d   = occ_q - OW'(1);
              state_d = S_DEQ;
            end else if (in_i.action == ACT_DISP) begin
              state_d = S_DISP;
            end else begin
              state_d = S_MM;
            end
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_status = res_status_q;
          state_d   = S_IDLE;
        end
      end

      S_DEQ: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_item  = rd_value;
          state_d  = S_IDLE;
        end
      end

      S_DISP: begin
        // one beat per held value; the next read goes out as this beat loads
        if (out_free) begin
          load_out   = 1'b1;
          ld_item    = rd_value;
          ld_last    = (scan_cnt_q == OW'(1));
          scan_cnt_d = scan_cnt_q - OW'(1);
          if (scan_cnt_q == OW'(1)) begin
            state_d = S_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = scan_idx_q;
            scan_idx_d = next_slot(scan_idx_q);
          end
        end
      end

      S_MM: begin
        // shared signed compare pair, one value per cycle
        if (rd_value < mn_q) begin
          mn_d = rd_value;
        end
        if (rd_value > mx_q) begin
          mx_d = rd_value;
        end
        scan_cnt_d = scan_cnt_q - OW'(1);
        if (scan_cnt_q == OW'(1)) begin
          state_d = S_MM_OUT;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = scan_idx_q;
          scan_idx_d = next_slot(scan_idx_q);
        end
      end

      S_MM_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_min   = mn_q;
          ld_max   = mx_q;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: a new beat replaces the one being taken
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.item_value = out_item_q;
  assign out_o.min_value  = out_min_q;
  assign out_o.max_value  = out_max_q;
  assign out_o.last       = out_last_q;

  // occupancy never passes the ring size
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(DEPTH))
    else $error("occupancy above depth");

  // an empty or full ring has head and tail on the same slot
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> (head_q == tail_q))
    else $error("head and tail disagree with occupancy");

  // the ram is only written when a slot is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !full)
    else $error("write into a full ring");

  // occupancy moves only on an accepted item
  a_occ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> (occ_q == $past(occ_q)))
    else $error("occupancy changed without an item");

  // a scan in progress always has values left to handle
  a_scan_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DISP) || (state_q == S_MM)) |-> (scan_cnt_q != '0))
    else $error("scan running with nothing left");

endmodule

`default_nettype wire

// ===== hw/rtl/fqmm_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module fqmm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== test/fifo_queue_min_max_scan_checker.sv =====
// checker for the fifo queue: watches both channels, predicts result beats and compares them
`default_nettype none

module fifo_queue_min_max_scan_checker #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fqmm_in_if          in_mon,
  fqmm_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned beats_due_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fqmm_pkg::*;

  localparam int unsigned PRINT_CAP = 100;

  typedef struct {
    status_e status;
    data_t   item_value;
    data_t   min_value;
    data_t   max_value;
    logic    last;
  } result_beat_t;

  // mirror of the queue contents
  data_t        ring [DEPTH];
  int unsigned  rd_ptr;
  int unsigned  wr_ptr;
  int unsigned  fill;

  result_beat_t due_beats [$];
  result_beat_t want;
  int unsigned  errors;

  initial begin
    rd_ptr       = 0;
    wr_ptr       = 0;
    fill         = 0;
    errors       = 0;
    fail_count_o = 0;
    beats_due_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // applies one action to the mirror and queues the beats it should produce
  task automatic apply_action(input action_e act, input data_t val);
    result_beat_t b;
    int unsigned  idx;
    data_t        lo;
    data_t        hi;
    b.status     = ST_OK;
    b.item_value = '0;
    b.min_value  = '0;
    b.max_value  = '0;
    b.last       = 1'b1;
    if (act == ACT_ENQ) begin
      if (fill >= DEPTH) begin
        b.status = ST_FULL;
      end else begin
        ring[wr_ptr] = val;
        wr_ptr       = (wr_ptr + 1) % DEPTH;
        fill++;
      end
      due_beats.push_back(b);
    end else if (fill == 0) begin
      b.status = ST_EMPTY;
      due_beats.push_back(b);
    end else if (act == ACT_DEQ) begin
      b.item_value = ring[rd_ptr];
      rd_ptr       = (rd_ptr + 1) % DEPTH;
      fill--;
      due_beats.push_back(b);
    end else if (act == ACT_DISP) begin
      idx = rd_ptr;
      for (int unsigned k = 0; k < fill; k++) begin
        b.item_value = ring[idx];
        b.last       = (k + 1 == fill);
        due_beats.push_back(b);
        idx = (idx + 1) % DEPTH;
      end
    end else begin
      idx = rd_ptr;
      lo  = ring[idx];
      hi  = lo;
      for (int unsigned k = 0; k < fill; k++) begin
        if (ring[idx] < lo) lo = ring[idx];
        if (ring[idx] > hi) hi = ring[idx];
        idx = (idx + 1) % DEPTH;
      end
      b.min_value = lo;
      b.max_value = hi;
      due_beats.push_back(b);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // the result side first: a beat seen here belongs to an older item
      if (out_mon.valid && out_mon.ready) begin
        if (due_beats.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (status %0d)",
                                    out_mon.status));
        end else begin
          want = due_beats.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_mon.status, want.status));
          if (out_mon.item_value !== want.item_value)
            report_mismatch($sformatf("item_value got %0d want %0d",
                                      out_mon.item_value, want.item_value));
          if (out_mon.min_value !== want.min_value)
            report_mismatch($sformatf("min_value got %0d want %0d",
                                      out_mon.min_value, want.min_value));
          if (out_mon.max_value !== want.max_value)
            report_mismatch($sformatf("max_value got %0d want %0d",
                                      out_mon.max_value, want.max_value));
          if (out_mon.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b",
                                      out_mon.last, want.last));
        end
      end
      if (in_mon.valid && in_mon.ready) apply_action(in_mon.action, in_mon.value);
      fail_count_o <= errors;
      beats_due_o  <= due_beats.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/fifo_queue_min_max_scan_tb.sv =====
// testbench top for the fifo queue: stimulus, receiver stalls, watchdog and verdict
`default_nettype none

module fifo_queue_min_max_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fqmm_pkg::*;

  localparam int unsigned DEPTH        = 32;
  // long receiver hold-off, well under the watchdog limit
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  // drain time covers a full min/max scan of DEPTH values, with some margin
  localparam int unsigned DRAIN_CYCLES = DEPTH + 16;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 20;

  logic clk_i;
  logic rst_ni;

  fqmm_in_if  in_ch ();
  fqmm_out_if out_ch ();

  int unsigned fail_count;
  int unsigned beats_due;

  // pacing knobs for sender and receiver, and the watchdog's idle count
  int unsigned tx_max_gap;
  int unsigned rx_max_gap;
  bit          hold_pending;
  int unsigned idle_cycles;

  fifo_queue_min_max_scan #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  fifo_queue_min_max_scan_checker #(
    .DEPTH(DEPTH)
  ) u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .beats_due_o (beats_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // helpers for the sender
  // ---------------------------------------------------------------------------

  // one action beat: optional idle gap, then hold valid until the block takes it
  task automatic offer(input action_e act, input data_t val);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop offering until every predicted beat has come back
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    // the checker count is registered, so the loop waits on the clock before every look
    do @(posedge clk_i); while (beats_due != 0);
  endtask

  // mix of extremes, small values near zero and full-range noise
  function automatic data_t pick_value();
    case ($urandom_range(0, 7))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      2, 3:    return data_t'($urandom_range(0, 20)) - data_t'(10);
      default: return data_t'($urandom);
    endcase
  endfunction

  // action mix leaning toward filling or toward draining the queue
  function automatic action_e pick_action(input bit draining);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < (draining ? 25 : 60)) return ACT_ENQ;
    if (r < 82)                   return ACT_DEQ;
    if (r < 91)                   return ACT_DISP;
    return ACT_MINMAX;
  endfunction

  // pacing: no idling, heavy idling or light idling
  function automatic int unsigned pick_gap_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 14;
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender: directed part, fill-up under receiver hold, random phases, verdict
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_ENQ;
    in_ch.value  <= '0;
    tx_max_gap   = 3;
    rx_max_gap   = 3;
    hold_pending = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: every non-enqueue action reports empty
    offer(ACT_DEQ, DATA_MAX);
    offer(ACT_DISP, DATA_MIN);
    offer(ACT_MINMAX, '0);

    // extremes and alternating bit patterns
    offer(ACT_ENQ, DATA_MAX);
    offer(ACT_ENQ, DATA_MIN);
    offer(ACT_ENQ, '0);
    offer(ACT_ENQ, -1);
    offer(ACT_ENQ, 1);
    offer(ACT_ENQ, data_t'(32'h5555_5555));
    offer(ACT_ENQ, data_t'(32'hAAAA_AAAA));
    offer(ACT_DISP, '0);
    offer(ACT_MINMAX, '0);

    // take out both extremes, then scan what is left
    offer(ACT_DEQ, '0);
    offer(ACT_DEQ, '0);
    offer(ACT_MINMAX, '0);
    offer(ACT_ENQ, 42);
    offer(ACT_DISP, '0);

    // drain to empty, then one dequeue too many
    repeat (6) offer(ACT_DEQ, '0);
    offer(ACT_DEQ, '0);

    // receiver goes quiet while enqueues keep coming: the block backs up,
    // the queue reaches full and later enqueues get dropped
    tx_max_gap   = 0;
    hold_pending = 1'b1;
    repeat (DEPTH + 8) offer(ACT_ENQ, pick_value());
    offer(ACT_DISP, '0);
    offer(ACT_MINMAX, '0);
    wait_quiet();

    // random phases, alternating drift so the queue swings between full and empty
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      tx_max_gap = pick_gap_limit();
      rx_max_gap = pick_gap_limit();
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        offer(pick_action(ph[0]), pick_value());
      end
      // halfway through, let the block run completely dry once more
      if (ph == PHASES / 2) wait_quiet();
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && beats_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall per beat, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = $urandom_range(0, rx_max_gap);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a beat on either channel means the block hung
  // ---------------------------------------------------------------------------
  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire
